FILE: design/i4rd_pkg.sv
// i4rd_pkg: shared widths, codes and the row-result record for the
// int4 x int8 row dot product block. No dependencies.
package i4rd_pkg;

  localparam int ACT_IDX_W  = 12;
  localparam int ACT_W      = 8;
  localparam int WBYTE_W    = 8;
  localparam int SCALE_W    = 32;
  localparam int ELEMS_W    = 13;
  localparam int ROW_W      = 16;
  localparam int SUM_W      = 24;
  localparam int RES_W      = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // |sum| * |activation scale|: 24 x 32 bits, at most 2^54
  localparam int PROD_W = 56;
  // times |row scale|: at most 2^85
  localparam int FULL_W = 88;
  // after rounding shift or left shift by up to 16 (fraction bits down to 8)
  localparam int MAG_W  = FULL_W + 17;

  localparam logic KIND_ACT    = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACT_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMS     = 1'b1;

  localparam logic [SCALE_W-1:0] ACT_SCALE_RST = 32'h0100_0000;
  localparam logic [ELEMS_W-1:0] ELEMS_RST     = 13'd4096;

  // Completed row handed from the accumulator to the scaling pipeline
  typedef struct packed {
    logic                      valid;
    logic [ROW_W-1:0]          row;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SCALE_W-1:0] row_scale;
  } row_done_t;

endpackage

FILE: design/i4rd_act_store.sv
// i4rd_act_store: activation memory split into even and odd banks so both
// activations of one weight byte come out of one registered read.
// Depends on i4rd_pkg.
module i4rd_act_store #(
  parameter int MAX_ELEMENTS = 4096,
  localparam int BANK_DEPTH = (MAX_ELEMENTS + 1) / 2,
  localparam int BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [i4rd_pkg::ACT_IDX_W-1:0]      wr_index,
  input  logic signed [i4rd_pkg::ACT_W-1:0]   wr_value,
  input  logic                                re,
  input  logic [BAW-1:0]                      rd_addr,
  output logic signed [i4rd_pkg::ACT_W-1:0]   rd_even,
  output logic signed [i4rd_pkg::ACT_W-1:0]   rd_odd
);
  import i4rd_pkg::*;

  logic [ACT_W-1:0] even_mem [BANK_DEPTH];
  logic [ACT_W-1:0] odd_mem  [BANK_DEPTH];
  logic             in_range;
  logic [BAW-1:0]   wr_addr;
  logic [ACT_W-1:0] rd_even_r, rd_odd_r;

  // drop loads beyond the store
  assign in_range = 32'(wr_index) < 32'(MAX_ELEMENTS);
  assign wr_addr  = BAW'(wr_index >> 1);

  always_ff @(posedge clk) begin
    if (we && in_range && !wr_index[0]) begin
      even_mem[wr_addr] <= wr_value;
    end
    if (we && in_range && wr_index[0]) begin
      odd_mem[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_even_r <= even_mem[rd_addr];
      rd_odd_r  <= odd_mem[rd_addr];
    end
  end

  assign rd_even = rd_even_r;
  assign rd_odd  = rd_odd_r;

endmodule

FILE: design/i4rd_row_acc.sv
// i4rd_row_acc: byte position, row counter and the row accumulator.
// Issues the store read, multiplies the nibbles and closes rows.
// Depends on i4rd_pkg.
module i4rd_row_acc #(
  parameter int MAX_ELEMENTS = 4096,
  localparam int HALF_MAX = MAX_ELEMENTS / 2,
  localparam int BPW = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic                                w_accept,
  input  logic [i4rd_pkg::WBYTE_W-1:0]        weight_byte,
  input  logic signed [i4rd_pkg::SCALE_W-1:0] row_scale,
  input  logic [i4rd_pkg::ELEMS_W-1:0]        elems,
  input  logic signed [i4rd_pkg::ACT_W-1:0]   x_even,
  input  logic signed [i4rd_pkg::ACT_W-1:0]   x_odd,
  output logic [BPW-1:0]                      rd_pos,
  output i4rd_pkg::row_done_t                 done
);
  import i4rd_pkg::*;

  localparam int BPR_W = $clog2(HALF_MAX + 1);
  localparam int CW = (ELEMS_W > $clog2(MAX_ELEMENTS + 1)) ? ELEMS_W
                                                           : $clog2(MAX_ELEMENTS + 1);

  logic [CW-1:0]             elems_clip;
  logic [BPR_W-1:0]          bpr_raw, bpr;
  logic [BPR_W:0]            bp_inc;
  logic                      last;
  logic [BPW-1:0]            bp_r, bp_nxt;
  logic [ROW_W-1:0]          row_cnt_r;

  logic                      v1_r, last1_r;
  logic [WBYTE_W-1:0]        w1_r;
  logic signed [SCALE_W-1:0] rs1_r;
  logic [ROW_W-1:0]          row1_r;

  logic signed [3:0]         n_lo, n_hi;
  logic signed [11:0]        p_lo, p_hi;
  logic [SUM_W-1:0]          acc_r, acc_sum;

  logic                      done_v_r;
  logic [ROW_W-1:0]          done_row_r;
  logic [SUM_W-1:0]          done_sum_r;
  logic signed [SCALE_W-1:0] done_rs_r;

  // bytes per row: clip to the store size, halve, at least one
  assign elems_clip = (CW'(elems) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(elems);
  assign bpr_raw    = BPR_W'(elems_clip >> 1);
  assign bpr        = (bpr_raw == '0) ? BPR_W'(1) : bpr_raw;
  assign bp_inc     = (BPR_W + 1)'(bp_r) + (BPR_W + 1)'(1);
  assign last       = bp_inc >= (BPR_W + 1)'(bpr);
  assign bp_nxt     = last ? '0 : BPW'(bp_inc);
  assign rd_pos     = bp_r;

  assign n_lo    = w1_r[3:0];
  assign n_hi    = w1_r[7:4];
  assign p_lo    = n_lo * x_even;
  assign p_hi    = n_hi * x_odd;
  assign acc_sum = acc_r + {{(SUM_W - 12){p_lo[11]}}, p_lo} + {{(SUM_W - 12){p_hi[11]}}, p_hi};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r      <= '0;
      row_cnt_r <= '0;
      v1_r      <= 1'b0;
      acc_r     <= '0;
      done_v_r  <= 1'b0;
    end else if (advance) begin
      v1_r     <= w_accept;
      done_v_r <= v1_r & last1_r;
      if (w_accept) begin
        bp_r <= bp_nxt;
        if (last) begin
          row_cnt_r <= row_cnt_r + 16'd1;
        end
      end
      if (v1_r) begin
        acc_r <= last1_r ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (w_accept) begin
        last1_r <= last;
        w1_r    <= weight_byte;
        rs1_r   <= row_scale;
        row1_r  <= row_cnt_r;
      end
      if (v1_r) begin
        done_row_r <= row1_r;
        done_sum_r <= acc_sum;
        done_rs_r  <= rs1_r;
      end
    end
  end

  assign done = '{valid: done_v_r, row: done_row_r, sum: done_sum_r, row_scale: done_rs_r};

  a_bp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(bp_r) < HALF_MAX)
    else $error("byte position ran past the last pair of the store");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    done_v_r |-> acc_r == '0)
    else $error("accumulator not cleared after a row closed");

  a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (w_accept && last) |=> row_cnt_r == 16'($past(row_cnt_r) + 16'd1))
    else $error("row counter did not advance on a row's last byte");

endmodule

FILE: design/i4rd_scale_pipe.sv
// i4rd_scale_pipe: sign-magnitude scaling of a row sum by both Q scales,
// rounding, saturation and the output register. Depends on i4rd_pkg.
module i4rd_scale_pipe #(
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  i4rd_pkg::row_done_t                 done,
  input  logic signed [i4rd_pkg::SCALE_W-1:0] act_scale,
  output logic                                out_valid,
  output logic [i4rd_pkg::ROW_W-1:0]          out_row_number,
  output logic signed [i4rd_pkg::SUM_W-1:0]   out_dot_sum,
  output logic signed [i4rd_pkg::RES_W-1:0]   out_scaled_result
);
  import i4rd_pkg::*;

  localparam int SH = 2 * SCALE_FRAC_BITS - 32;

  typedef struct packed {
    logic             neg;
    logic [ROW_W-1:0] row;
    logic [SUM_W-1:0] sum;
  } tag_t;

  logic               a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, out_v_r;
  tag_t               a_tag_r, b_tag_r, c_tag_r, d_tag_r, e_tag_r;
  logic [SUM_W-1:0]   a_ms_r;
  logic [SCALE_W-1:0] a_ma_r, a_mr_r, b_mr_r;
  logic [PROD_W-1:0]  b_prod_r;
  logic [63:0]        c_lo_r;
  logic [PROD_W-1:0]  c_hi_r;
  logic [FULL_W-1:0]  d_full_r;
  logic [MAG_W-1:0]   e_mag_nxt, e_mag_r;

  logic [SUM_W-1:0]   sum_mag;
  logic [SCALE_W-1:0] as_mag, rs_mag;
  logic [RES_W-1:0]   lim, mag_sat;
  logic               over;

  logic [ROW_W-1:0]   out_row_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic [RES_W-1:0]   out_res_r;

  assign sum_mag = done.sum[SUM_W-1] ? SUM_W'(-done.sum) : done.sum;
  assign as_mag  = act_scale[SCALE_W-1] ? SCALE_W'(-act_scale) : act_scale;
  assign rs_mag  = done.row_scale[SCALE_W-1] ? SCALE_W'(-done.row_scale) : done.row_scale;

  // round half away from zero on the magnitude, or widen to 32 fraction bits
  generate
    if (SH > 0) begin : g_round
      localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (SH - 1);
      assign e_mag_nxt = (MAG_W'(d_full_r) + HALF) >> SH;
    end else begin : g_widen
      localparam int LSH = -SH;
      assign e_mag_nxt = MAG_W'(d_full_r) << LSH;
    end
  endgenerate

  assign lim     = e_tag_r.neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign over    = (|e_mag_r[MAG_W-1:RES_W]) || (e_mag_r[RES_W-1:0] > lim);
  assign mag_sat = over ? lim : e_mag_r[RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      e_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      a_v_r   <= done.valid;
      b_v_r   <= a_v_r;
      c_v_r   <= b_v_r;
      d_v_r   <= c_v_r;
      e_v_r   <= d_v_r;
      out_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_tag_r  <= '{neg: done.sum[SUM_W-1] ^ act_scale[SCALE_W-1] ^ done.row_scale[SCALE_W-1],
                    row: done.row, sum: done.sum};
      a_ms_r   <= sum_mag;
      a_ma_r   <= as_mag;
      a_mr_r   <= rs_mag;

      b_tag_r  <= a_tag_r;
      b_mr_r   <= a_mr_r;
      b_prod_r <= a_ms_r * a_ma_r;

      c_tag_r  <= b_tag_r;
      c_lo_r   <= b_prod_r[31:0] * b_mr_r;
      c_hi_r   <= b_prod_r[PROD_W-1:32] * b_mr_r;

      d_tag_r  <= c_tag_r;
      d_full_r <= FULL_W'(c_lo_r) + {c_hi_r, 32'b0};

      e_tag_r  <= d_tag_r;
      e_mag_r  <= e_mag_nxt;

      out_row_r <= e_tag_r.row;
      out_sum_r <= e_tag_r.sum;
      out_res_r <= e_tag_r.neg ? RES_W'(-mag_sat) : mag_sat;
    end
  end

  assign out_valid         = out_v_r;
  assign out_row_number    = out_row_r;
  assign out_dot_sum       = out_sum_r;
  assign out_scaled_result = out_res_r;

  a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_sum_r == '0) |-> out_res_r == '0)
    else $error("zero row sum gave a nonzero scaled result");

endmodule

FILE: design/int4_int8_row_dot_scaled.sv
// int4_int8_row_dot_scaled: top level of the int4-weight, int8-activation
// row dot product with Q8.24 scaling. Depends on i4rd_pkg, i4rd_act_store,
// i4rd_row_acc and i4rd_scale_pipe.
//
// Input channel (in_valid / in_stall): one item per transfer. With
// in_kind = KIND_ACT it writes in_act_value at in_act_index of the store;
// indexes beyond the store are dropped. With in_kind = KIND_WEIGHT it carries
// one packed byte of two signed nibbles, low nibble against the even
// activation; in_row_scale counts only on the last byte of a row.
// Result channel (out_valid / out_stall): one transfer per completed row with
// the row number, the integer sum and the scaled Q32.32 result.
// Configuration (cfg_we / cfg_index / cfg_wdata): write only while idle.
// Throughput: one item per cycle while in_stall is low. After a row's last
// byte transfers, the store read is registered, the accumulator closes the
// row and the scaling pipeline runs its stages (magnitudes, 24x32 multiply,
// 32x32 partial products, 88-bit combine, rounding, saturation into the
// output register), where the row's result then sits.
// Reset: counters, accumulator and configuration return to defaults; the
// store is not cleared, so load activations before use. Stall: while a
// result waits under out_stall the whole pipeline holds and in_stall rises.
module int4_int8_row_dot_scaled #(
  parameter int MAX_ELEMENTS    = 4096,
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic [i4rd_pkg::ACT_IDX_W-1:0]        in_act_index,
  input  logic signed [i4rd_pkg::ACT_W-1:0]     in_act_value,
  input  logic [i4rd_pkg::WBYTE_W-1:0]          in_weight_byte,
  input  logic signed [i4rd_pkg::SCALE_W-1:0]   in_row_scale,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [i4rd_pkg::ROW_W-1:0]            out_row_number,
  output logic signed [i4rd_pkg::SUM_W-1:0]     out_dot_sum,
  output logic signed [i4rd_pkg::RES_W-1:0]     out_scaled_result,
  input  logic                                  cfg_we,
  input  logic [i4rd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [i4rd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import i4rd_pkg::*;

  localparam int HALF_MAX   = MAX_ELEMENTS / 2;
  localparam int BPW        = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;
  localparam int BANK_DEPTH = (MAX_ELEMENTS + 1) / 2;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic                      advance;
  logic                      accept, w_accept, a_accept;
  logic signed [SCALE_W-1:0] act_scale_r;
  logic [ELEMS_W-1:0]        elems_r;
  logic [BPW-1:0]            rd_pos;
  logic signed [ACT_W-1:0]   x_even, x_odd;
  row_done_t                 done;

  // advance the pipeline unless a finished result is held by the receiver
  assign advance  = rst_n & (~out_valid | ~out_stall);
  assign in_stall = ~advance;
  assign accept   = in_valid & ~in_stall;
  assign w_accept = accept & (in_kind == KIND_WEIGHT);
  assign a_accept = accept & (in_kind == KIND_ACT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_scale_r <= ACT_SCALE_RST;
      elems_r     <= ELEMS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACT_SCALE: act_scale_r <= cfg_wdata;
        CFG_ELEMS:     elems_r     <= cfg_wdata[ELEMS_W-1:0];
        default: ;
      endcase
    end
  end

  // activation store: loads write, weight transfers read the pair at the byte position
  i4rd_act_store #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_store (
    .clk      (clk),
    .we       (a_accept),
    .wr_index (in_act_index),
    .wr_value (in_act_value),
    .re       (w_accept),
    .rd_addr  (BAW'(rd_pos)),
    .rd_even  (x_even),
    .rd_odd   (x_odd)
  );

  // byte position, row counting and accumulation
  i4rd_row_acc #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .w_accept    (w_accept),
    .weight_byte (in_weight_byte),
    .row_scale   (in_row_scale),
    .elems       (elems_r),
    .x_even      (x_even),
    .x_odd       (x_odd),
    .rd_pos      (rd_pos),
    .done        (done)
  );

  // scale, round, saturate and hold the result for transfer
  i4rd_scale_pipe #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .advance           (advance),
    .done              (done),
    .act_scale         (act_scale_r),
    .out_valid         (out_valid),
    .out_row_number    (out_row_number),
    .out_dot_sum       (out_dot_sum),
    .out_scaled_result (out_scaled_result)
  );

endmodule
